FILE: hw/rtl/pfrd_pkg.sv
// Shared widths, tap tables, register indexes and payload types of the pulse filter.
package pfrd_pkg;

  localparam int RING_DEPTH_DEFAULT = 27;

  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int ACC_W    = 32;
  localparam int GAIN_W   = 16;
  localparam int PROD_W   = ACC_W + GAIN_W;
  localparam int GAIN_FRAC = 8;
  localparam int TERM_W   = SAMPLE_W + 2;
  localparam int RATE_W   = 32;

  // Ring taps, as offsets from the write position; the oldest entry has offset zero.
  localparam int NUM_TAPS  = 11;
  localparam int NUM_TERMS = NUM_TAPS + 1;
  localparam int TAP_OFFSET [NUM_TAPS] = '{26, 24, 21, 20, 19, 9, 8, 7, 4, 2, 0};
  // Term zero is the incoming sample, term k is ring tap k-1.
  localparam int TERM_WEIGHT [NUM_TERMS] = '{-1, -1, -1, 2, 2, 2, -2, -2, -2, 1, 1, 1};
  localparam int TERM_IDX_W = $clog2(NUM_TERMS);
  localparam int TIME_TAP = 14;

  localparam int MULT_CNT_W = $clog2(GAIN_W);
  localparam int DIV_CNT_W  = $clog2(RATE_W);

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_SCALE  = 1'd1;
  localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RESET = 16'd256;
  localparam logic [RATE_W-1:0] RATE_SCALE_RESET  = 32'd960000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]          timestamp;
  } in_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] filtered;
    logic [RATE_W-1:0]       rate;
    logic                    peak_found;
  } out_item_t;

endpackage

FILE: hw/rtl/pfrd_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface pfrd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/pfrd_delay_line.sv
// Sample and timestamp delay lines with fixed filter taps, shifted once per item.
module pfrd_delay_line #(
  parameter int RING_DEPTH = pfrd_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                shift,
  input  logic [pfrd_pkg::SAMPLE_W-1:0]                       sample_in,
  input  logic [pfrd_pkg::TIME_W-1:0]                         time_in,
  output logic [pfrd_pkg::NUM_TAPS-1:0][pfrd_pkg::SAMPLE_W-1:0] taps,
  output logic [pfrd_pkg::TIME_W-1:0]                         delayed_time
);
  import pfrd_pkg::*;

  localparam int TimeLen = RING_DEPTH - TIME_TAP;

  // Entry zero holds the most recent item.
  logic [RING_DEPTH-1:0][SAMPLE_W-1:0] sample_line;
  logic [TimeLen-1:0][TIME_W-1:0]      time_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_line <= '0;
      time_line   <= '0;
    end else if (shift) begin
      sample_line <= {sample_line[RING_DEPTH-2:0], sample_in};
      time_line   <= {time_line[TimeLen-2:0], time_in};
    end
  end

  // A tap at offset c sees the sample written RING_DEPTH - c items ago.
  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
    assign taps[k] = sample_line[RING_DEPTH-1-TAP_OFFSET[k]];
  end

  assign delayed_time = time_line[TimeLen-1];

endmodule

FILE: hw/rtl/pfrd_serial_mult.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift and add.
module pfrd_serial_mult (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pfrd_pkg::ACC_W-1:0]    multiplicand,
  input  logic [pfrd_pkg::GAIN_W-1:0]   multiplier,
  output logic                          done,
  output logic [pfrd_pkg::PROD_W-1:0]   product
);
  import pfrd_pkg::*;

  logic                  busy;
  logic [MULT_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]     mcand;
  logic [GAIN_W-1:0]     mplier;
  logic                  last_bit;

  assign last_bit = (cnt == MULT_CNT_W'(GAIN_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && last_bit;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last_bit) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // The sign bit of the multiplier carries negative weight, so its step subtracts.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand   <= {{GAIN_W{multiplicand[ACC_W-1]}}, multiplicand};
      mplier  <= multiplier;
      product <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        product <= last_bit ? product - mcand : product + mcand;
      end
      mcand  <= {mcand[PROD_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[GAIN_W-1:1]};
    end
  end

endmodule

FILE: hw/rtl/pfrd_serial_div.sv
// Restoring unsigned divider: one quotient bit per cycle.
module pfrd_serial_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pfrd_pkg::RATE_W-1:0] numerator,
  input  logic [pfrd_pkg::RATE_W-1:0] denominator,
  output logic                        done,
  output logic [pfrd_pkg::RATE_W-1:0] quotient
);
  import pfrd_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RATE_W-1:0]    remainder;
  logic [RATE_W-1:0]    divisor;
  logic [RATE_W:0]      rem_shift;
  logic [RATE_W:0]      diff;

  // The numerator shifts out of the quotient register as quotient bits shift in.
  assign rem_shift = {remainder, quotient[RATE_W-1]};
  assign diff      = rem_shift - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == DIV_CNT_W'(RATE_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(RATE_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= numerator;
      remainder <= '0;
      divisor   <= denominator;
    end else if (busy) begin
      quotient  <= {quotient[RATE_W-2:0], ~diff[RATE_W]};
      remainder <= diff[RATE_W] ? rem_shift[RATE_W-1:0] : diff[RATE_W-1:0];
    end
  end

endmodule

FILE: hw/rtl/pulse_filter_rate_detector_top.sv
// Pulse filter and peak-to-peak rate detector, top level.
// Takes one sample at a time: once a sample is accepted, the twelve filter terms are added into the
// accumulator one per cycle, the gain multiply runs bit-serially (16 shift-and-add steps), the peak
// decision follows and the result is then loaded into the output register. An item that fires a
// peak after an earlier nonzero peak time, with a nonzero interval, also runs the bit-serial rate
// divider between the peak decision and the output register. A new sample is taken while the
// previous result still waits in the output register; the next result is held in its last step
// until that register is free. Configuration writes must land only while no item is in flight;
// the block itself does not enforce this.
module pulse_filter_rate_detector_top #(
  parameter int RING_DEPTH = pfrd_pkg::RING_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  pfrd_stream_if.sink                      samples,
  pfrd_stream_if.source                    results,
  input  logic                             wr_en,
  input  logic [pfrd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [pfrd_pkg::CFG_DATA_W-1:0]  wr_data
);
  import pfrd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAPS,
    S_MULT,
    S_PEAK,
    S_DIV,
    S_FINISH
  } state_t;

  state_t state;

  logic [GAIN_W-1:0] output_gain;
  logic [RATE_W-1:0] rate_scale;

  logic [SAMPLE_W-1:0]     x_r;
  logic [TIME_W-1:0]       t_r;
  logic [TERM_IDX_W-1:0]   term_idx;
  logic [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0] lobe_min;
  logic                    detected;
  logic [TIME_W-1:0]       last_peak;
  logic [RATE_W-1:0]       held_rate;
  logic signed [ACC_W-1:0] value_r;
  logic                    fired_r;
  logic                    out_valid;
  logic signed [ACC_W-1:0] out_filtered;
  logic [RATE_W-1:0]       out_rate;
  logic                    out_peak;
  logic                    mult_start;

  logic [NUM_TAPS-1:0][SAMPLE_W-1:0] taps;
  logic [TIME_W-1:0]                 delayed_time;
  logic                              line_shift;

  logic               mult_done;
  logic [PROD_W-1:0]  product;
  logic               div_start;
  logic               div_done;
  logic [RATE_W-1:0]  quotient;

  logic [SAMPLE_W-1:0]            term_sample;
  logic signed [TERM_W-1:0]       term_ext;
  logic signed [TERM_W-1:0]       term_mag;
  logic signed [TERM_W-1:0]       term_value;
  logic signed [PROD_W-GAIN_FRAC-1:0] shifted;
  logic signed [ACC_W-1:0]        value_c;
  logic [TIME_W-1:0]              interval;
  logic                           fire;
  logic                           out_free;
  logic                           in_xfer;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_gain <= OUTPUT_GAIN_RESET;
      rate_scale  <= RATE_SCALE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_OUTPUT_GAIN: output_gain <= wr_data[GAIN_W-1:0];
        REG_RATE_SCALE:  rate_scale  <= wr_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  pfrd_delay_line #(
    .RING_DEPTH(RING_DEPTH)
  ) u_delay_line (
    .clk         (clk),
    .rst         (rst),
    .shift       (line_shift),
    .sample_in   (x_r),
    .time_in     (t_r),
    .taps        (taps),
    .delayed_time(delayed_time)
  );

  pfrd_serial_mult u_mult (
    .clk         (clk),
    .rst         (rst),
    .start       (mult_start),
    .multiplicand(acc),
    .multiplier  (output_gain),
    .done        (mult_done),
    .product     (product)
  );

  pfrd_serial_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .numerator  (rate_scale),
    .denominator(interval),
    .done       (div_done),
    .quotient   (quotient)
  );

  assign in_xfer  = samples.valid && samples.ready;
  assign out_free = !out_valid || results.ready;
  assign samples.ready = (state == S_IDLE);
  assign line_shift = (state == S_FINISH) && out_free;

  // Weighted filter term for the current step; weights are plus or minus one or two.
  always_comb begin
    term_sample = (term_idx == '0) ? x_r : taps[term_idx - 1'b1];
    term_ext    = {{(TERM_W - SAMPLE_W){term_sample[SAMPLE_W-1]}}, term_sample};
    term_mag    = (TERM_WEIGHT[term_idx] == 2 || TERM_WEIGHT[term_idx] == -2)
                  ? (term_ext <<< 1) : term_ext;
    term_value  = (TERM_WEIGHT[term_idx] < 0) ? -term_mag : term_mag;
  end

  // The arithmetic right shift of the product floors the Q8.8 scaling, then saturates.
  always_comb begin
    shifted = signed'(product[PROD_W-1:GAIN_FRAC]);
    if ((&shifted[PROD_W-GAIN_FRAC-1:ACC_W-1]) || !(|shifted[PROD_W-GAIN_FRAC-1:ACC_W-1])) begin
      value_c = shifted[ACC_W-1:0];
    end else if (shifted[PROD_W-GAIN_FRAC-1]) begin
      value_c = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      value_c = {1'b0, {(ACC_W-1){1'b1}}};
    end
  end

  // A zero output counts as part of the lobe, so a rise to zero can fire.
  assign interval  = delayed_time - last_peak;
  assign fire      = (value_c[ACC_W-1] || (value_c == '0)) && (value_c > lobe_min);
  assign div_start = (state == S_PEAK) && fire && (last_peak != '0) && (interval != '0);

  assign results.valid              = out_valid;
  assign results.payload.filtered   = out_filtered;
  assign results.payload.rate       = out_rate;
  assign results.payload.peak_found = out_peak;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      term_idx   <= '0;
      acc        <= '0;
      lobe_min   <= '0;
      detected   <= 1'b0;
      last_peak  <= '0;
      held_rate  <= '0;
      out_valid  <= 1'b0;
      mult_start <= 1'b0;
    end else begin
      mult_start <= (state == S_TAPS) && (term_idx == TERM_IDX_W'(NUM_TERMS - 1));
      if (line_shift) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            x_r      <= samples.payload.sample;
            t_r      <= samples.payload.timestamp;
            term_idx <= '0;
            state    <= S_TAPS;
          end
        end
        S_TAPS: begin
          acc      <= acc + {{(ACC_W - TERM_W){term_value[TERM_W-1]}}, term_value};
          term_idx <= term_idx + 1'b1;
          if (term_idx == TERM_IDX_W'(NUM_TERMS - 1)) begin
            state <= S_MULT;
          end
        end
        S_MULT: begin
          if (mult_done) begin
            state <= S_PEAK;
          end
        end
        S_PEAK: begin
          value_r <= value_c;
          fired_r <= fire;
          state   <= S_FINISH;
          if (!value_c[ACC_W-1] && (value_c != '0)) begin
            detected <= 1'b0;
            lobe_min <= '0;
          end else if (fire) begin
            // With no earlier peak time the firing only records its time.
            if (last_peak != '0) begin
              if (interval == '0) begin
                held_rate <= '1;
              end else begin
                state <= S_DIV;
              end
            end
            last_peak <= delayed_time;
            lobe_min  <= '0;
            detected  <= 1'b1;
          end else if (!detected) begin
            lobe_min <= value_c;
          end
        end
        S_DIV: begin
          if (div_done) begin
            held_rate <= quotient;
            state     <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_filtered <= value_r;
            out_rate     <= held_rate;
            out_peak     <= fired_r;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_lobe_cleared: assert property (@(posedge clk) disable iff (rst)
    detected |-> lobe_min == '0)
    else $error("lobe minimum held while a detection is latched");

  a_mult_done_state: assert property (@(posedge clk) disable iff (rst)
    mult_done |-> state == S_MULT)
    else $error("multiplier finished outside the multiply step");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> state == S_TAPS && term_idx == '0)
    else $error("accepted sample did not start the filter sum");
`endif

endmodule
